// ----- rtl/wpc_pkg.sv -----
// Shared types, widths, constants and tables for the waypoint P controller.
// Used by wpc_iter and waypoint_p_controller; no dependencies of its own.
package wpc_pkg;

    localparam int NUM_WAYPOINTS_DEF = 8;

    localparam int POS_W      = 16;
    localparam int HEAD_W     = 15;
    localparam int DIFF_W     = 17;
    localparam int GAIN_W     = 12;
    localparam int SPEED_W    = 16;
    localparam int TOL_W      = 12;
    localparam int RATE_W     = 20;
    localparam int SLOT_W     = 3;
    localparam int WP_W       = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // register map
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TOL   = 2'd2;

    localparam logic [GAIN_W-1:0]  GAIN_RESET  = 12'd384;
    localparam logic [SPEED_W-1:0] SPEED_RESET = 16'd6144;
    localparam logic [TOL_W-1:0]   TOL_RESET   = 12'd82;

    // sqrt / CORDIC sizing
    localparam int SQX_W        = 32;   // dx^2 < 2^32
    localparam int RAD_W        = 35;   // 4*(dx^2+dy^2) < 2^35
    localparam int ROOT_W       = 18;
    localparam int SQRT_STEPS   = 18;
    localparam int CORDIC_STEPS = 16;
    localparam int CNT_W        = 5;
    localparam int CX_W         = 28;
    localparam int CZ_W         = 19;
    localparam int MUL_W        = 19;
    localparam int PROD_W       = 2 * MUL_W;

    localparam logic signed [CZ_W-1:0] HALF_PI_Q16 = 19'sd102944;

    typedef struct packed {
        logic start;   // load operands, clear step count
        logic step;    // run one sqrt/CORDIC iteration
    } iter_ctrl_t;

    function automatic logic signed [CZ_W-1:0] atan_q16(input logic [3:0] i);
        logic signed [CZ_W-1:0] a;
        unique case (i)
            4'd0:    a = 19'sd51472;
            4'd1:    a = 19'sd30385;
            4'd2:    a = 19'sd16054;
            4'd3:    a = 19'sd8150;
            4'd4:    a = 19'sd4091;
            4'd5:    a = 19'sd2047;
            4'd6:    a = 19'sd1024;
            4'd7:    a = 19'sd512;
            4'd8:    a = 19'sd256;
            4'd9:    a = 19'sd128;
            4'd10:   a = 19'sd64;
            4'd11:   a = 19'sd32;
            4'd12:   a = 19'sd16;
            4'd13:   a = 19'sd8;
            4'd14:   a = 19'sd4;
            default: a = 19'sd2;
        endcase
        return a;
    endfunction

    // power-on waypoints, y in the upper half; entries past the eighth are zero
    function automatic logic [WP_W-1:0] default_point(input logic [7:0] i);
        logic [WP_W-1:0] p;
        unique case (i)
            8'd0:    p = {16'd17490, 16'd11346};
            8'd1:    p = {16'd15442, 16'd13394};
            8'd2:    p = {16'd13394, 16'd11346};
            8'd3:    p = {16'd11346, 16'd13394};
            8'd4:    p = {16'd17490, 16'd14418};
            8'd5:    p = {16'd11346, 16'd15442};
            8'd6:    p = {16'd17490, 16'd16056};
            8'd7:    p = {16'd11346, 16'd17490};
            default: p = '0;
        endcase
        return p;
    endfunction

endpackage

// ----- rtl/wpc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the waypoint table.
module wpc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/wpc_iter.sv -----
// Iterative unit: one restoring square-root bit and one CORDIC vectoring
// step per cycle with ctrl.step high, side by side. Depends on wpc_pkg.
module wpc_iter
    import wpc_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  iter_ctrl_t               ctrl,
    input  logic signed [DIFF_W-1:0] dx,
    input  logic signed [DIFF_W-1:0] dy,
    input  logic [RAD_W-1:0]         rad,
    output logic                     last,
    output logic [ROOT_W-1:0]        root,
    output logic signed [CZ_W-1:0]   bearing
);

    logic [CNT_W-1:0]        cnt_reg;
    logic [RAD_W-1:0]        v_reg, r_reg, bit_reg;
    logic signed [CX_W-1:0]  cx_reg, cy_reg;
    logic signed [CZ_W-1:0]  cz_reg;

    logic [RAD_W:0]          trial;
    logic signed [CX_W-1:0]  x0, y0, xs, ys;
    logic [3:0]              sh;

    assign trial = {1'b0, r_reg} + {1'b0, bit_reg};
    assign sh    = cnt_reg[3:0];
    assign xs    = cx_reg >>> sh;
    assign ys    = cy_reg >>> sh;
    assign x0    = {{(CX_W-DIFF_W-8){dx[DIFF_W-1]}}, dx, 8'b0};
    assign y0    = {{(CX_W-DIFF_W-8){dy[DIFF_W-1]}}, dy, 8'b0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (ctrl.start)
        begin
            cnt_reg <= '0;
        end
        else if (ctrl.step && !last)
        begin
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            v_reg   <= rad;
            r_reg   <= '0;
            bit_reg <= {1'b1, {(RAD_W-1){1'b0}}};
            // fold the left half-plane into the right
            if (x0 < 0)
            begin
                if (y0 >= 0)
                begin
                    cx_reg <= y0;
                    cy_reg <= -x0;
                    cz_reg <= HALF_PI_Q16;
                end
                else
                begin
                    cx_reg <= -y0;
                    cy_reg <= x0;
                    cz_reg <= -HALF_PI_Q16;
                end
            end
            else
            begin
                cx_reg <= x0;
                cy_reg <= y0;
                cz_reg <= '0;
            end
        end
        else if (ctrl.step)
        begin
            if ({1'b0, v_reg} >= trial)
            begin
                v_reg <= v_reg - trial[RAD_W-1:0];
                r_reg <= (r_reg >> 1) + bit_reg;
            end
            else
            begin
                r_reg <= r_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;

            if (cnt_reg < CNT_W'(CORDIC_STEPS))
            begin
                if (cy_reg > 0)
                begin
                    cx_reg <= cx_reg + ys;
                    cy_reg <= cy_reg - xs;
                    cz_reg <= cz_reg + atan_q16(sh);
                end
                else if (cy_reg < 0)
                begin
                    cx_reg <= cx_reg - ys;
                    cy_reg <= cy_reg + xs;
                    cz_reg <= cz_reg - atan_q16(sh);
                end
            end
        end
    end

    assign last    = (cnt_reg == CNT_W'(SQRT_STEPS - 1));
    assign root    = r_reg[ROOT_W-1:0];
    assign bearing = cz_reg;

endmodule

// ----- rtl/waypoint_p_controller.sv -----
// Go-to-goal proportional controller over a stored waypoint table.
// Depends on wpc_pkg, wpc_ram and wpc_iter.
//
// Usage:
//   Input channel (in_valid/in_stall) carries one item: op=0 is a pose
//   sample (pos_x, pos_y, heading), op=1 loads waypoint_slot with
//   (pos_x, pos_y). A load gives no result; loads to a slot at or past
//   NUM_WAYPOINTS are dropped.
//   A pose item gives one result on the output channel (out_valid/
//   out_stall): linear_speed, angular_rate, target_slot, goal_reached.
//   A pose passes from accept to out_valid through setup (S_DIFF, S_SQX,
//   S_SQY, S_SUM), 18 iterations of the shared sqrt/CORDIC unit (the
//   sqrt sets the count), S_DECIDE, S_MUL and the output write in S_FIN.
//   in_stall is high all that time, so one pose is in flight at a time.
//   Registers (gain, speed_limit, tolerance) are written through cfg_we,
//   cfg_index, cfg_data; the user must write them only while the block
//   is idle; the block does not check it. Reset restores the default
//   registers, the power-on waypoints and target index 0. While
//   out_stall holds a result, the next item can still be accepted; a
//   second pose waits in S_FIN until the output register frees up.
module waypoint_p_controller
    import wpc_pkg::*;
#(
    parameter int NUM_WAYPOINTS = NUM_WAYPOINTS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic                      op,
    input  logic signed [POS_W-1:0]   pos_x,
    input  logic signed [POS_W-1:0]   pos_y,
    input  logic signed [HEAD_W-1:0]  heading,
    input  logic [SLOT_W-1:0]         waypoint_slot,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [SPEED_W-1:0]        linear_speed,
    output logic signed [RATE_W-1:0]  angular_rate,
    output logic [SLOT_W-1:0]         target_slot,
    output logic                      goal_reached,
    input  logic                      cfg_we,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [CFG_DATA_W-1:0]     cfg_data
);

    localparam int IDX_W = $clog2(NUM_WAYPOINTS);

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_DIFF   = 9'b000000010,
        S_SQX    = 9'b000000100,
        S_SQY    = 9'b000001000,
        S_SUM    = 9'b000010000,
        S_ITER   = 9'b000100000,
        S_DECIDE = 9'b001000000,
        S_MUL    = 9'b010000000,
        S_FIN    = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    logic [GAIN_W-1:0]        gain_reg;
    logic [SPEED_W-1:0]       speed_reg;
    logic [TOL_W-1:0]         tol_reg;
    logic [IDX_W-1:0]         idx_reg;
    logic [NUM_WAYPOINTS-1:0] wp_valid_reg;

    logic signed [POS_W-1:0]  px_reg, py_reg;
    logic signed [HEAD_W-1:0] hd_reg;
    logic                     rd_valid_reg;
    logic [WP_W-1:0]          dflt_reg;
    logic signed [DIFF_W-1:0] dx_reg, dy_reg;
    logic [SQX_W-1:0]         sqx_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [DIFF_W-1:0] err_reg;
    logic                     reached_reg, use_rate_reg;

    logic                     out_valid_reg;
    logic [SPEED_W-1:0]       lin_reg;
    logic signed [RATE_W-1:0] rate_reg;
    logic [SLOT_W-1:0]        slot_out_reg;
    logic                     goal_reg;

    logic                     accept, pose_acc, load_acc, slot_ok;
    logic                     out_free, fin_go;
    logic [WP_W-1:0]          ram_rdata, wp;
    logic signed [POS_W-1:0]  tx, ty;
    logic [RAD_W-1:0]         rad;
    iter_ctrl_t               iter_ctrl;
    logic                     iter_last;
    logic [ROOT_W-1:0]        root;
    logic signed [CZ_W-1:0]   bearing;
    logic signed [CZ_W:0]     ang_full;
    logic signed [DIFF_W-1:0] err, mag;
    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0] mul_prod;
    logic [PROD_W-1:0]        lin_full;
    logic signed [PROD_W-1:0] rate_full;
    logic [IDX_W-1:0]         idx_new;

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;
    assign pose_acc = accept && !op;
    assign load_acc = accept && op;
    assign slot_ok  = (32'(waypoint_slot) < NUM_WAYPOINTS);
    assign out_free = !out_valid_reg || !out_stall;
    assign fin_go   = (state_reg == S_FIN) && out_free;

    // ---------------- configuration ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg  <= GAIN_RESET;
            speed_reg <= SPEED_RESET;
            tol_reg   <= TOL_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_GAIN:  gain_reg  <= cfg_data[GAIN_W-1:0];
                CFG_SPEED: speed_reg <= cfg_data[SPEED_W-1:0];
                CFG_TOL:   tol_reg   <= cfg_data[TOL_W-1:0];
                default:   ;
            endcase
        end
    end

    // ---------------- waypoint table ----------------
    wpc_ram #(
        .WIDTH (WP_W),
        .DEPTH (NUM_WAYPOINTS)
    ) u_table (
        .clk   (clk),
        .we    (load_acc && slot_ok),
        .waddr (IDX_W'(waypoint_slot)),
        .wdata ({pos_y, pos_x}),
        .re    (pose_acc),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    // entries never loaded read as their power-on value
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_valid_reg <= '0;
        end
        else if (load_acc && slot_ok)
        begin
            wp_valid_reg[IDX_W'(waypoint_slot)] <= 1'b1;
        end
    end

    assign wp = rd_valid_reg ? ram_rdata : dflt_reg;
    assign tx = wp[POS_W-1:0];
    assign ty = wp[WP_W-1:POS_W];

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   if (pose_acc) state_next = S_DIFF;
            S_DIFF:   state_next = S_SQX;
            S_SQX:    state_next = S_SQY;
            S_SQY:    state_next = S_SUM;
            S_SUM:    state_next = S_ITER;
            S_ITER:   if (iter_last) state_next = S_DECIDE;
            S_DECIDE: state_next = S_MUL;
            S_MUL:    state_next = S_FIN;
            S_FIN:    if (out_free) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // ---------------- shared multiplier ----------------
    always_comb
    begin
        priority if (state_reg == S_SQX)
        begin
            mul_a = MUL_W'(dx_reg);
            mul_b = MUL_W'(dx_reg);
        end
        else if (state_reg == S_SQY)
        begin
            mul_a = MUL_W'(dy_reg);
            mul_b = MUL_W'(dy_reg);
        end
        else
        begin
            mul_a = $signed({{(MUL_W-GAIN_W){1'b0}}, gain_reg});
            mul_b = use_rate_reg ? MUL_W'(err_reg)
                                 : $signed({{(MUL_W-ROOT_W){1'b0}}, root});
        end
    end

    assign mul_prod = mul_a * mul_b;

    // ---------------- sqrt / bearing unit ----------------
    assign rad = {SQX_W'(0) + {1'b0, sqx_reg} + {1'b0, prod_reg[SQX_W-1:0]}, 2'b00};

    assign iter_ctrl.start = (state_reg == S_SUM);
    assign iter_ctrl.step  = (state_reg == S_ITER);

    wpc_iter u_iter (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (iter_ctrl),
        .dx      (dx_reg),
        .dy      (dy_reg),
        .rad     (rad),
        .last    (iter_last),
        .root    (root),
        .bearing (bearing)
    );

    // bearing rounded half up from 2^-16 to 2^-12 rad
    assign ang_full = ((CZ_W+1)'(bearing) + (CZ_W+1)'(8)) >>> 4;
    assign err      = DIFF_W'(ang_full) - DIFF_W'(hd_reg);
    assign mag      = err[DIFF_W-1] ? -err : err;

    // ---------------- datapath ----------------
    always_ff @(posedge clk)
    begin
        if (pose_acc)
        begin
            px_reg       <= pos_x;
            py_reg       <= pos_y;
            hd_reg       <= heading;
            rd_valid_reg <= wp_valid_reg[idx_reg];
            dflt_reg     <= default_point(8'(idx_reg));
        end
        if (state_reg == S_DIFF)
        begin
            dx_reg <= DIFF_W'(tx) - DIFF_W'(px_reg);
            dy_reg <= DIFF_W'(ty) - DIFF_W'(py_reg);
        end
        if (state_reg == S_SQY)
        begin
            sqx_reg <= prod_reg[SQX_W-1:0];
        end
        if (state_reg == S_SQX || state_reg == S_SQY || state_reg == S_MUL)
        begin
            prod_reg <= mul_prod;
        end
        if (state_reg == S_DECIDE)
        begin
            reached_reg  <= ({{(ROOT_W-TOL_W){1'b0}}, tol_reg} >= root);
            err_reg      <= err;
            use_rate_reg <= ($unsigned(mag) > {{(DIFF_W-TOL_W){1'b0}}, tol_reg});
        end
    end

    // ---------------- result and target index ----------------
    assign lin_full  = ($unsigned(prod_reg) + PROD_W'(256)) >> 9;
    assign rate_full = (prod_reg + PROD_W'(128)) >>> 8;
    assign idx_new   = (reached_reg && idx_reg != IDX_W'(NUM_WAYPOINTS - 1))
                       ? idx_reg + 1'b1 : idx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (fin_go)
            begin
                idx_reg       <= idx_new;
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fin_go)
        begin
            slot_out_reg <= SLOT_W'(idx_new);
            goal_reg     <= reached_reg;
            if (reached_reg)
            begin
                lin_reg  <= '0;
                rate_reg <= '0;
            end
            else if (use_rate_reg)
            begin
                lin_reg  <= '0;
                rate_reg <= RATE_W'(rate_full);
            end
            else
            begin
                lin_reg  <= (lin_full > PROD_W'(speed_reg)) ? speed_reg
                                                            : SPEED_W'(lin_full);
                rate_reg <= '0;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign linear_speed = lin_reg;
    assign angular_rate = rate_reg;
    assign target_slot  = slot_out_reg;
    assign goal_reached = goal_reg;

endmodule
